/* hw/rtl/srpr_pkg.sv */
// ----------------------------------------------------------------------------
// srpr_pkg
// Types, codes and constants of the shared ring packet receiver.
// ----------------------------------------------------------------------------
package srpr_pkg;

  localparam int unsigned RING_WORDS_DEF = 1024;
  localparam int unsigned PORT_IDX_W     = 10;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned LEN_W          = 24;
  localparam int unsigned TAG_W          = 6;
  localparam int unsigned TAG_LSB        = 24;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 24;

  localparam logic [LEN_W-1:0] MAX_BYTES_RST = 24'd1024;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_DRAIN  = 2'd1;
  localparam logic [1:0] KIND_RESYNC = 2'd2;

  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_STALE    = 3'd2;
  localparam logic [2:0] ST_OVERSIZE = 3'd3;
  localparam logic [2:0] ST_OVERRUN  = 3'd4;
  localparam logic [2:0] ST_RESYNC   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SESSION_TAG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES   = 1'b1;

  typedef struct packed {
    logic [1:0]            kind;
    logic [PORT_IDX_W-1:0] word_index;
    logic [WORD_W-1:0]     word_value;
    logic [PORT_IDX_W-1:0] remote_wr_idx;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [WORD_W-1:0]     data_word;
    logic [2:0]            bytes_valid;
    logic                  last;
    logic [PORT_IDX_W-1:0] rd_idx;
  } out_item_t;

  typedef struct packed {
    logic       emit;
    logic       enter;
    logic       last;
    logic [2:0] status;
  } hdr_ctl_t;

endpackage

/* hw/rtl/srpr_ring_mem.sv */
// ----------------------------------------------------------------------------
// srpr_ring_mem
// Single-port ring word memory with registered read data.
// ----------------------------------------------------------------------------
module srpr_ring_mem
  import srpr_pkg::*;
#(
  parameter int unsigned DEPTH = RING_WORDS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [WORD_W-1:0] wdata_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] ring_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ring_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= ring_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/srpr_hdr_eval.sv */
// ----------------------------------------------------------------------------
// srpr_hdr_eval
// Header word check: fit, session tag, size limit and new read index.
// ----------------------------------------------------------------------------
module srpr_hdr_eval
  import srpr_pkg::*;
#(
  parameter int unsigned AW = $clog2(RING_WORDS_DEF)
) (
  input  logic [WORD_W-1:0] hdr_i,
  input  logic [AW-1:0]     rp_next_i,
  input  logic [AW-1:0]     wi_i,
  input  logic [TAG_W-1:0]  session_tag_i,
  input  logic [LEN_W-1:0]  max_bytes_i,
  output hdr_ctl_t          ctl_o,
  output logic [AW-1:0]     rp_o,
  output logic [LEN_W-1:0]  size_o
);

  logic [LEN_W-1:0] size;
  logic [TAG_W-1:0] tag;
  logic [LEN_W:0]   size_rnd;
  logic [LEN_W-2:0] words;
  logic [AW-1:0]    waiting;
  logic [AW-1:0]    skip_rp;
  logic             overrun;

  assign size     = hdr_i[LEN_W-1:0];
  assign tag      = hdr_i[TAG_LSB +: TAG_W];
  assign size_rnd = {1'b0, size} + (LEN_W+1)'(3);
  assign words    = size_rnd[LEN_W:2];
  assign waiting  = wi_i - rp_next_i;
  assign skip_rp  = rp_next_i + words[AW-1:0];
  assign overrun  = 32'(words) > 32'(waiting);
  assign size_o   = size;

  always_comb begin
    ctl_o.emit   = 1'b1;
    ctl_o.enter  = 1'b0;
    ctl_o.last   = 1'b0;
    ctl_o.status = ST_DATA;
    rp_o         = rp_next_i;
    if (overrun) begin
      ctl_o.status = ST_OVERRUN;
      rp_o         = wi_i;
    end else if (tag != session_tag_i) begin
      ctl_o.status = ST_STALE;
      rp_o         = skip_rp;
    end else if (size > max_bytes_i) begin
      ctl_o.status = ST_OVERSIZE;
      rp_o         = skip_rp;
    end else if (size == '0) begin
      ctl_o.last = 1'b1;
    end else begin
      ctl_o.emit  = 1'b0;
      ctl_o.enter = 1'b1;
    end
  end

endmodule

/* hw/rtl/shared_ring_packet_receiver_unit.sv */
// Result path: a drain or resync passes the stage 1 register, then the output register.
// Throughput: one transfer per cycle while the output is not stalled, set by the single ring memory port.
// A drain that reads a header holds off the next transfer until stage 1 has evaluated it and advanced.
// Reset clears read index, packet state, pipeline and registers; ring words
// are not cleared and there is no clearing pass.
// ----------------------------------------------------------------------------
// shared_ring_packet_receiver_unit
// Receive side of a word ring in shared memory: ring writes, drains, resync.
// RING_WORDS must be a power of two.
// ----------------------------------------------------------------------------
module shared_ring_packet_receiver_unit
  import srpr_pkg::*;
#(
  parameter int unsigned RING_WORDS = RING_WORDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(RING_WORDS);

  logic [TAG_W-1:0]  session_tag_q;
  logic [LEN_W-1:0]  max_bytes_q;

  logic [AW-1:0]     rp_q;
  logic              in_pkt_q;
  logic [LEN_W-1:0]  left_q;

  logic              s1_valid_q;
  logic              s1_hdr_q;
  logic              s1_mem_q;
  logic [2:0]        s1_status_q;
  logic [2:0]        s1_bv_q;
  logic              s1_last_q;
  logic [AW-1:0]     s1_rdidx_q;
  logic [AW-1:0]     s1_wi_q;

  logic              out_valid_q;
  out_item_t         out_item_q;

  logic              in_acc;
  logic              s1_adv;
  logic [AW-1:0]     wi;
  logic [AW-1:0]     widx;
  logic [AW-1:0]     rp_inc;
  logic [2:0]        nbytes;
  logic [LEN_W-1:0]  left_nx;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_rdata;
  hdr_ctl_t          hdr_ctl;
  logic [AW-1:0]     hdr_rp;
  logic [LEN_W-1:0]  hdr_size;
  logic              s1_emit;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && (s1_hdr_q || !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign wi      = AW'(in_item_i.remote_wr_idx);
  assign widx    = AW'(in_item_i.word_index);
  assign rp_inc  = rp_q + AW'(1);
  assign nbytes  = (left_q < LEN_W'(4)) ? left_q[2:0] : 3'd4;
  assign left_nx = left_q - LEN_W'(nbytes);

  assign mem_we   = in_acc && (in_item_i.kind == KIND_WRITE);
  assign mem_re   = in_acc && (in_item_i.kind == KIND_DRAIN) && (in_pkt_q || (rp_q != wi));
  assign mem_addr = (in_item_i.kind == KIND_WRITE) ? widx : rp_q;

  srpr_ring_mem #(
    .DEPTH (RING_WORDS),
    .AW    (AW)
  ) u_ring_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (in_item_i.word_value),
    .rdata_o (mem_rdata)
  );

  srpr_hdr_eval #(
    .AW (AW)
  ) u_hdr_eval (
    .hdr_i         (mem_rdata),
    .rp_next_i     (s1_rdidx_q),
    .wi_i          (s1_wi_q),
    .session_tag_i (session_tag_q),
    .max_bytes_i   (max_bytes_q),
    .ctl_o         (hdr_ctl),
    .rp_o          (hdr_rp),
    .size_o        (hdr_size)
  );

  assign s1_emit = !s1_hdr_q || hdr_ctl.emit;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_tag_q <= '0;
      max_bytes_q   <= MAX_BYTES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SESSION_TAG: session_tag_q <= cfg_data_i[TAG_W-1:0];
        CFG_MAX_BYTES:   max_bytes_q   <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // read index and packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q     <= '0;
      in_pkt_q <= 1'b0;
      left_q   <= '0;
    end else if (in_acc) begin
      case (in_item_i.kind)
        KIND_RESYNC: begin
          rp_q     <= wi;
          in_pkt_q <= 1'b0;
          left_q   <= '0;
        end
        KIND_DRAIN: begin
          if (in_pkt_q) begin
            rp_q     <= rp_inc;
            left_q   <= left_nx;
            in_pkt_q <= (left_nx != '0);
          end
        end
        default: ;
      endcase
    end else if (s1_adv && s1_hdr_q) begin
      rp_q <= hdr_rp;
      if (hdr_ctl.enter) begin
        in_pkt_q <= 1'b1;
        left_q   <= hdr_size;
      end
    end
  end

  // stage 1: memory read in flight, or a resync or empty result that needs no read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc && (in_item_i.kind == KIND_DRAIN || in_item_i.kind == KIND_RESYNC)) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_hdr_q    <= 1'b0;
      s1_mem_q    <= 1'b0;
      s1_status_q <= ST_RESYNC;
      s1_bv_q     <= 3'd0;
      s1_last_q   <= 1'b0;
      s1_rdidx_q  <= wi;
      s1_wi_q     <= wi;
      if (in_item_i.kind == KIND_DRAIN) begin
        if (in_pkt_q) begin
          s1_mem_q    <= 1'b1;
          s1_status_q <= ST_DATA;
          s1_bv_q     <= nbytes;
          s1_last_q   <= (left_nx == '0);
          s1_rdidx_q  <= rp_inc;
        end else if (rp_q == wi) begin
          s1_status_q <= ST_EMPTY;
          s1_rdidx_q  <= rp_q;
        end else begin
          s1_hdr_q   <= 1'b1;
          s1_rdidx_q <= rp_inc;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_emit;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit) begin
      if (s1_hdr_q) begin
        out_item_q.status      <= hdr_ctl.status;
        out_item_q.data_word   <= '0;
        out_item_q.bytes_valid <= 3'd0;
        out_item_q.last        <= hdr_ctl.last;
        out_item_q.rd_idx      <= PORT_IDX_W'(hdr_rp);
      end else begin
        out_item_q.status      <= s1_status_q;
        out_item_q.data_word   <= s1_mem_q ? mem_rdata : '0;
        out_item_q.bytes_valid <= s1_bv_q;
        out_item_q.last        <= s1_last_q;
        out_item_q.rd_idx      <= PORT_IDX_W'(s1_rdidx_q);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_pkt_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pkt_q |-> (left_q != '0))
    else $error("inside a packet with no bytes left");

  a_hdr_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_hdr_q) |-> in_stall_o)
    else $error("transfer taken while header evaluation pending");

  a_mem_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("ring memory read and write in one cycle");

  a_pkt_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.kind == KIND_DRAIN && in_pkt_q) |=> (rp_q == $past(rp_inc)))
    else $error("read index did not advance on packet data drain");

  a_no_result_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !s1_adv)
    else $error("stage 1 advanced over a held result");

endmodule
